// ----- design/fmva_pkg.sv -----
`default_nettype none
package fmva_pkg;

  localparam int CHANNELS    = 16;
  localparam int PATCH_WORDS = 16;
  localparam int WORDS_READ  = 5;

  localparam logic [2:0] KIND_NOTE_ON    = 3'd0;
  localparam logic [2:0] KIND_NOTE_OFF   = 3'd1;
  localparam logic [2:0] KIND_PITCH_BEND = 3'd2;
  localparam logic [2:0] KIND_CONTROLLER = 3'd3;
  localparam logic [2:0] KIND_PROGRAM    = 3'd4;
  localparam logic [2:0] KIND_LOAD_PATCH = 3'd5;
  localparam logic [2:0] KIND_SILENCE    = 3'd6;

  localparam logic [2:0] WORD_FIX    = 3'd0;
  localparam logic [2:0] WORD_MODFCN = 3'd1;
  localparam logic [2:0] WORD_LEVEL  = 3'd2;
  localparam logic [2:0] WORD_CARFCN = 3'd3;
  localparam logic [2:0] WORD_CARLVL = 3'd4;

  localparam logic [6:0] CTRL_VOLUME   = 7'd7;
  localparam logic [3:0] DRUM_CHANNEL  = 4'd8;
  localparam logic [6:0] VOLUME_RESET  = 7'd127;
  localparam logic [7:0] BEND_RESET    = 8'd128;
  localparam logic [7:0] MASTER_RESET  = 8'd15;
  localparam logic [3:0] FN_MELODIC    = 4'd5;
  localparam logic [3:0] FN_DRUM       = 4'd7;

  localparam logic [19:0] NOTE_STEP [128] = '{
    20'd134, 20'd142, 20'd150, 20'd159, 20'd169, 20'd179, 20'd189, 20'd201,
    20'd213, 20'd225, 20'd239, 20'd253, 20'd268, 20'd284, 20'd301, 20'd319,
    20'd338, 20'd358, 20'd379, 20'd401, 20'd425, 20'd451, 20'd477, 20'd506,
    20'd536, 20'd568, 20'd601, 20'd637, 20'd675, 20'd715, 20'd758, 20'd803,
    20'd851, 20'd901, 20'd955, 20'd1011, 20'd1072, 20'd1135, 20'd1203, 20'd1274,
    20'd1350, 20'd1430, 20'd1515, 20'd1606, 20'd1701, 20'd1802, 20'd1909, 20'd2023,
    20'd2143, 20'd2271, 20'd2406, 20'd2549, 20'd2700, 20'd2861, 20'd3031, 20'd3211,
    20'd3402, 20'd3604, 20'd3819, 20'd4046, 20'd4286, 20'd4541, 20'd4811, 20'd5098,
    20'd5401, 20'd5722, 20'd6062, 20'd6422, 20'd6804, 20'd7209, 20'd7638, 20'd8092,
    20'd8573, 20'd9083, 20'd9623, 20'd10195, 20'd10801, 20'd11444, 20'd12124,
    20'd12845, 20'd13609, 20'd14418, 20'd15275, 20'd16184, 20'd17146, 20'd18165,
    20'd19246, 20'd20390, 20'd21602, 20'd22887, 20'd24248, 20'd25690, 20'd27217,
    20'd28836, 20'd30551, 20'd32367, 20'd34292, 20'd36331, 20'd38491, 20'd40780,
    20'd43205, 20'd45774, 20'd48496, 20'd51380, 20'd54435, 20'd57672, 20'd61101,
    20'd64734, 20'd68584, 20'd72662, 20'd76982, 20'd81560, 20'd86410, 20'd91548,
    20'd96992, 20'd102759, 20'd108870, 20'd115343, 20'd122202, 20'd129469,
    20'd137167, 20'd145324, 20'd153965, 20'd163120, 20'd172820, 20'd183096,
    20'd193984, 20'd205519
  };

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [6:0]  ctrl_number;
    logic [6:0]  ctrl_value;
    logic [13:0] bend;
    logic [6:0]  program_req;
    logic [7:0]  patch_index;
    logic [3:0]  patch_word_index;
    logic [31:0] patch_word;
  } msg_t;

  typedef struct packed {
    logic [6:0]  reg_index;
    logic [31:0] reg_value;
    logic        clear_all;
    logic        last;
  } res_t;

  typedef struct packed {
    logic       take;
    logic       slot_div;
    logic       slot_fix;
    logic       rd_issue;
    logic [2:0] rd_idx;
    logic       vol_mul;
    logic       vol_scale;
    logic       lvl_mul;
    logic       alloc;
    logic       calc;
    logic       off_check;
    logic       emit_first;
    logic       emit_second;
  } cmd_t;

  typedef struct packed {
    logic alloc_ok;
    logic off_ok;
    logic res_two;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- design/fmva_datapath.sv -----
`default_nettype none
module fmva_datapath #(
  parameter int PATCHES = 256,
  parameter int VOICES  = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire fmva_pkg::msg_t msg,
  input  wire logic           cfg_we,
  input  wire logic [7:0]     cfg_data,
  input  wire fmva_pkg::cmd_t cmd,
  output fmva_pkg::sts_t      sts,
  input  wire logic           res_stall,
  output logic                res_valid,
  output fmva_pkg::res_t      res
);

  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int PAIRS = VOICES / 2;
  localparam int PW    = $clog2(PATCHES);
  localparam int DEPTH = PATCHES * fmva_pkg::PATCH_WORDS;
  localparam int RECIP = 65536 / PATCHES;

  logic [31:0] patch_mem [DEPTH];

  logic [7:0] master_volume;
  logic [6:0] chan_volume  [fmva_pkg::CHANNELS];
  logic [7:0] chan_bend    [fmva_pkg::CHANNELS];
  logic [6:0] chan_program [fmva_pkg::CHANNELS];
  logic [4:0] chan_voice   [fmva_pkg::CHANNELS];
  logic       chan_valid   [fmva_pkg::CHANNELS];
  logic [6:0] chan_note    [fmva_pkg::CHANNELS];
  logic       busy         [VOICES];

  logic [3:0]  ch;
  logic [6:0]  note;
  logic [6:0]  vel;
  logic [7:0]  prg;
  logic [7:0]  quot;
  logic [PW-1:0] slot;
  logic [31:0] rd_data;
  logic        rd_pend;
  logic [2:0]  rd_word;
  logic        fix_note_en;
  logic        fix_pair;
  logic [7:0]  fineadj;
  logic [7:0]  fixnote;
  logic [7:0]  modfcn;
  logic [7:0]  carfcn;
  logic [5:0]  modlvl;
  logic [5:0]  carlvl;
  logic [3:0]  fbconn;
  logic [15:0] basenote;
  logic [6:0]  vol1;
  logic [6:0]  vol;
  logic [12:0] mod_prod;
  logic [12:0] car_prod;
  logic [4:0]  code;
  fmva_pkg::res_t res1;
  fmva_pkg::res_t res2;
  logic        res_two;

  logic [7:0]  prg_now;
  logic [23:0] div_prod;
  logic [16:0] qp;
  logic [16:0] rem;
  logic [16:0] rem_fix;
  logic [14:0] scale_prod;
  logic [10:0] scale_sh;
  logic        want_pair;
  logic        pair_any;
  logic        single_any;
  logic [3:0]  pair_idx;
  logic [3:0]  single_idx;
  logic        found;
  logic [4:0]  new_code;
  logic [4:0]  cur_code;
  logic [4:0]  vn1;
  logic [4:0]  vn2;
  logic [4:0]  off_vn1;
  logic [4:0]  off_vn2;
  logic        off_match;
  logic signed [17:0] nsum;
  logic signed [17:0] n0;
  logic signed [17:0] n2;
  logic [6:0]  note1;
  logic [6:0]  note2;
  logic [7:0]  bnd;
  logic [5:0]  pbl;
  logic signed [8:0] nb;
  logic [6:0]  noteb;
  logic [5:0]  mod_base;
  logic [7:0]  mod_sh;
  logic [8:0]  mod_dbl;
  logic [7:0]  mod_raw;
  logic [6:0]  modv;
  logic [6:0]  carv;
  logic [3:0]  fn;
  logic [31:0] rv1;
  logic [31:0] rv2;
  logic [31:0] rvs;

  function automatic logic [5:0] att(input logic [6:0] level);
    att = 6'd63 - 6'(level >> 1);
  endfunction

  assign prg_now  = {ch == fmva_pkg::DRUM_CHANNEL, chan_program[ch]};
  assign div_prod = 24'(prg_now) * 24'(RECIP);
  assign qp       = 17'(quot) * 17'(PATCHES);
  assign rem      = 17'(prg) - qp;
  assign rem_fix  = (rem >= 17'(PATCHES)) ? rem - 17'(PATCHES) : rem;

  assign scale_prod = 15'(vol1) * 15'(master_volume);
  assign scale_sh   = scale_prod[14:4];

  always_comb begin
    want_pair  = !fbconn[0] || (modfcn != carfcn) || fix_pair;
    pair_any   = 1'b0;
    single_any = 1'b0;
    pair_idx   = '0;
    single_idx = '0;
    for (int i = PAIRS - 1; i >= 0; i--) begin
      if (!busy[2*i] && !busy[2*i+1]) begin
        pair_any = 1'b1;
        pair_idx = 4'(i);
      end
      if (!busy[2*i]) begin
        single_any = 1'b1;
        single_idx = 4'(i);
      end
    end
    if (want_pair && pair_any) begin
      new_code = {1'b1, pair_idx};
      found    = 1'b1;
    end else if (single_any) begin
      new_code = {1'b0, single_idx};
      found    = 1'b1;
    end else begin
      new_code = '0;
      found    = 1'b0;
    end
    cur_code = chan_valid[ch] ? chan_voice[ch] : new_code;
  end

  assign vn1 = {cur_code[3:0], 1'b0};
  assign vn2 = vn1 + 5'd1;
  assign off_vn1 = {chan_voice[ch][3:0], 1'b0};
  assign off_vn2 = off_vn1 + 5'd1;
  assign off_match = chan_valid[ch] && (chan_note[ch] == note);

  always_comb begin
    nsum = $signed({11'b0, note}) + $signed({{2{basenote[15]}}, basenote});
    n0 = (nsum < 0) ? 18'sd0 : nsum;
    if (fix_note_en) begin
      n0 = $signed({10'b0, fixnote});
    end
    note1 = (n0 > 18'sd127) ? 7'd127 : n0[6:0];
    n2 = n0 + $signed({10'b0, fineadj}) - 18'sd128;
    if (n2 < 0) begin
      note2 = 7'd0;
    end else if (n2 > 18'sd127) begin
      note2 = 7'd127;
    end else begin
      note2 = n2[6:0];
    end

    bnd = chan_bend[ch];
    pbl = (bnd == 8'd0) ? 6'd0 : 6'({1'b0, bnd[7:3]}) - 6'd16;
    nb  = $signed({2'b0, note}) + $signed({{3{pbl[5]}}, pbl});
    if (nb < 0) begin
      noteb = 7'd0;
    end else if (nb > 9'sd127) begin
      noteb = 7'd127;
    end else begin
      noteb = nb[6:0];
    end

    mod_base = 6'd63 - modlvl;
    case (fbconn[3:1])
      3'd0: mod_sh = 8'd0;
      3'd1: mod_sh = 8'(mod_base >> 4);
      3'd2: mod_sh = 8'(mod_base >> 3);
      3'd3: mod_sh = 8'(mod_base >> 2);
      3'd4: mod_sh = 8'(mod_base >> 1);
      3'd5: mod_sh = 8'(mod_base);
      3'd6: mod_sh = 8'(mod_base) << 1;
      default: mod_sh = 8'(mod_base) << 2;
    endcase
    mod_dbl = {mod_sh, 1'b0};
    mod_raw = fbconn[0] ? 8'(mod_prod >> 6) : mod_dbl[7:0];
    modv    = (mod_raw > 8'd127) ? 7'd127 : mod_raw[6:0];
    carv    = 7'(car_prod >> 6);

    fn = (ch == fmva_pkg::DRUM_CHANNEL) ? fmva_pkg::FN_DRUM : fmva_pkg::FN_MELODIC;
    if (modfcn == carfcn || fbconn[0]) begin
      fn = modfcn[3:0];
    end

    rv1 = {1'b0, carfcn[2:0], att(carv), !fbconn[0], 1'b0, fmva_pkg::NOTE_STEP[note1]};
    rv2 = {1'b0, modfcn[2:0], att(modv), 2'b00, fmva_pkg::NOTE_STEP[note2]};
    rvs = {fn, att(vol), 2'b00, fmva_pkg::NOTE_STEP[noteb]};
  end

  always_ff @(posedge clk) begin
    if (cmd.take && msg.kind == fmva_pkg::KIND_LOAD_PATCH &&
        {1'b0, msg.patch_index} < 9'(PATCHES)) begin
      patch_mem[{msg.patch_index[PW-1:0], msg.patch_word_index}] <= msg.patch_word;
    end
    if (cmd.rd_issue) begin
      rd_data <= patch_mem[{slot, 4'(cmd.rd_idx)}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      master_volume <= fmva_pkg::MASTER_RESET;
      for (int i = 0; i < fmva_pkg::CHANNELS; i++) begin
        chan_volume[i]  <= fmva_pkg::VOLUME_RESET;
        chan_bend[i]    <= fmva_pkg::BEND_RESET;
        chan_program[i] <= '0;
        chan_voice[i]   <= '0;
        chan_valid[i]   <= 1'b0;
        chan_note[i]    <= '0;
      end
      for (int v = 0; v < VOICES; v++) begin
        busy[v] <= 1'b0;
      end
      rd_pend   <= 1'b0;
      res_two   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        master_volume <= cfg_data;
      end
      rd_pend <= cmd.rd_issue;
      if (cmd.take) begin
        case (msg.kind)
          fmva_pkg::KIND_PITCH_BEND: chan_bend[msg.channel] <= msg.bend[13:6];
          fmva_pkg::KIND_CONTROLLER: begin
            if (msg.ctrl_number == fmva_pkg::CTRL_VOLUME) begin
              chan_volume[msg.channel] <= msg.ctrl_value;
            end
          end
          fmva_pkg::KIND_PROGRAM: chan_program[msg.channel] <= msg.program_req;
          fmva_pkg::KIND_SILENCE: begin
            for (int i = 0; i < fmva_pkg::CHANNELS; i++) begin
              chan_volume[i] <= fmva_pkg::VOLUME_RESET;
              chan_bend[i]   <= fmva_pkg::BEND_RESET;
              chan_voice[i]  <= '0;
              chan_valid[i]  <= 1'b0;
            end
            for (int v = 0; v < VOICES; v++) begin
              busy[v] <= 1'b0;
            end
            res_two <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.alloc && (chan_valid[ch] || found)) begin
        chan_voice[ch] <= cur_code;
        chan_valid[ch] <= 1'b1;
        chan_note[ch]  <= note;
        busy[vn1[VW-1:0]] <= 1'b1;
        if (cur_code[4]) begin
          busy[vn2[VW-1:0]] <= 1'b1;
        end
      end
      if (cmd.calc) begin
        res_two <= code[4];
      end
      if (cmd.off_check && off_match) begin
        chan_valid[ch] <= 1'b0;
        busy[off_vn1[VW-1:0]] <= 1'b0;
        if (chan_voice[ch][4]) begin
          busy[off_vn2[VW-1:0]] <= 1'b0;
        end
        res_two <= chan_voice[ch][4];
      end
      if (cmd.emit_first || cmd.emit_second) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ch   <= msg.channel;
      note <= msg.note;
      vel  <= msg.velocity;
      res1 <= '{reg_index: '0, reg_value: '0, clear_all: 1'b1, last: 1'b1};
    end
    if (cmd.slot_div) begin
      prg  <= prg_now;
      quot <= div_prod[23:16];
    end
    if (cmd.slot_fix) begin
      slot <= rem_fix[PW-1:0];
    end
    if (rd_pend) begin
      case (rd_word)
        fmva_pkg::WORD_FIX: begin
          fix_note_en <= rd_data[0];
          fix_pair    <= rd_data[2];
          fineadj     <= rd_data[23:16];
          fixnote     <= rd_data[31:24];
        end
        fmva_pkg::WORD_MODFCN: modfcn <= rd_data[31:24];
        fmva_pkg::WORD_LEVEL: begin
          modlvl <= rd_data[13:8];
          fbconn <= rd_data[19:16];
        end
        fmva_pkg::WORD_CARFCN: carfcn <= rd_data[23:16];
        fmva_pkg::WORD_CARLVL: begin
          carlvl   <= rd_data[5:0];
          basenote <= rd_data[31:16];
        end
        default: ;
      endcase
    end
    rd_word <= cmd.rd_idx;
    if (cmd.vol_mul) begin
      vol1 <= 7'((14'(chan_volume[ch]) * 14'(vel)) >> 7);
    end
    if (cmd.vol_scale) begin
      vol <= (scale_sh > 11'd127) ? 7'd127 : scale_sh[6:0];
    end
    if (cmd.lvl_mul) begin
      mod_prod <= 13'(6'd63 - modlvl) * 13'(vol);
      car_prod <= 13'(6'd63 - carlvl) * 13'(vol);
    end
    if (cmd.alloc) begin
      code <= cur_code;
    end
    if (cmd.calc) begin
      if (code[4]) begin
        res1 <= '{reg_index: {vn1, 2'b00}, reg_value: rv1, clear_all: 1'b0, last: 1'b0};
        res2 <= '{reg_index: {vn2, 2'b00}, reg_value: rv2, clear_all: 1'b0, last: 1'b1};
      end else begin
        res1 <= '{reg_index: {vn1, 2'b00}, reg_value: rvs, clear_all: 1'b0, last: 1'b1};
      end
    end
    if (cmd.off_check) begin
      res1 <= '{reg_index: {off_vn1, 2'b00}, reg_value: '0, clear_all: 1'b0,
                last: !chan_voice[ch][4]};
      res2 <= '{reg_index: {off_vn2, 2'b00}, reg_value: '0, clear_all: 1'b0, last: 1'b1};
    end
    if (cmd.emit_first) begin
      res <= res1;
    end else if (cmd.emit_second) begin
      res <= res2;
    end
  end

  assign sts.alloc_ok = chan_valid[ch] || found;
  assign sts.off_ok   = off_match;
  assign sts.res_two  = res_two;
  assign sts.out_free = !res_valid || !res_stall;

endmodule
`default_nettype wire

// ----- design/fmva_control.sv -----
`default_nettype none
module fmva_control (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           msg_valid,
  input  wire logic [2:0]     msg_kind,
  input  wire fmva_pkg::sts_t sts,
  output fmva_pkg::cmd_t      cmd,
  output logic                busy
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_FIX, S_READ, S_VOL, S_SCALE, S_MUL, S_ALLOC, S_CALC,
    S_OFF, S_EMIT1, S_EMIT2
  } state_t;

  state_t     state;
  logic [2:0] cnt;

  always_comb begin
    cmd             = '0;
    cmd.take        = (state == S_IDLE) && msg_valid;
    cmd.slot_div    = (state == S_DIV);
    cmd.slot_fix    = (state == S_FIX);
    cmd.rd_issue    = (state == S_READ);
    cmd.rd_idx      = cnt;
    cmd.vol_mul     = (state == S_VOL);
    cmd.vol_scale   = (state == S_SCALE);
    cmd.lvl_mul     = (state == S_MUL);
    cmd.alloc       = (state == S_ALLOC);
    cmd.calc        = (state == S_CALC);
    cmd.off_check   = (state == S_OFF);
    cmd.emit_first  = (state == S_EMIT1) && sts.out_free;
    cmd.emit_second = (state == S_EMIT2) && sts.out_free;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (msg_valid) begin
            case (msg_kind)
              fmva_pkg::KIND_NOTE_ON:  state <= S_DIV;
              fmva_pkg::KIND_NOTE_OFF: state <= S_OFF;
              fmva_pkg::KIND_SILENCE:  state <= S_EMIT1;
              default:                 state <= S_IDLE;
            endcase
          end
        end
        S_DIV: state <= S_FIX;
        S_FIX: state <= S_READ;
        S_READ: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'(fmva_pkg::WORDS_READ - 1)) begin
            state <= S_VOL;
          end
        end
        S_VOL:   state <= S_SCALE;
        S_SCALE: state <= S_MUL;
        S_MUL:   state <= S_ALLOC;
        S_ALLOC: state <= sts.alloc_ok ? S_CALC : S_IDLE;
        S_CALC:  state <= S_EMIT1;
        S_OFF:   state <= sts.off_ok ? S_EMIT1 : S_IDLE;
        S_EMIT1: begin
          if (sts.out_free) begin
            state <= sts.res_two ? S_EMIT2 : S_IDLE;
          end
        end
        S_EMIT2: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_first || cmd.emit_second) |-> sts.out_free)
    else $error("result loaded while output register full");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> (state != S_IDLE) || !(($past(msg_kind) == fmva_pkg::KIND_NOTE_ON) ||
                  ($past(msg_kind) == fmva_pkg::KIND_NOTE_OFF) ||
                  ($past(msg_kind) == fmva_pkg::KIND_SILENCE)))
    else $error("result-bearing transfer did not leave idle");

  a_read_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (cnt < 3'(fmva_pkg::WORDS_READ)))
    else $error("patch read count overrun");

endmodule
`default_nettype wire

// ----- design/midi_fm_voice_allocator_unit.sv -----
`default_nettype none
// Turns MIDI channel events into writes to the first word of each FM voice.
// One event is taken at a time. Silence gives one clear-all transfer.
// Note-on runs through the patch slot arithmetic, five reads of the patch
// memory, three multiply stages, voice allocation and word build; output
// stalls can hold it up. The patch memory (PATCHES x 16 words) has no
// reset and needs no clearing pass.
module midi_fm_voice_allocator_unit #(
  parameter int PATCHES = 256,
  parameter int VOICES  = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           msg_valid,
  output logic                msg_stall,
  input  wire fmva_pkg::msg_t msg,
  output logic                res_valid,
  input  wire logic           res_stall,
  output fmva_pkg::res_t      res,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [7:0]     cfg_data
);

  fmva_pkg::cmd_t cmd;
  fmva_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  fmva_control u_control (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_kind  (msg.kind),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (msg_stall)
  );

  fmva_datapath #(
    .PATCHES (PATCHES),
    .VOICES  (VOICES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .msg       (msg),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule
`default_nettype wire

// ----- tb/midi_fm_voice_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
module midi_fm_voice_allocator_unit_tb;

  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int LIMIT = 800000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic msg_valid = 1'b0;
  logic msg_stall;
  fmva_pkg::msg_t msg = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  fmva_pkg::res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  midi_fm_voice_allocator_unit dut (
    .clk(clk), .rst(rst),
    .msg_valid(msg_valid), .msg_stall(msg_stall), .msg(msg),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  fmva_pkg::msg_t event_q[$];
  fmva_pkg::res_t voice_write_q[$];
  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;
  int events_sent = 0;
  int writes_seen = 0;
  int cycles = 0;
  int hold_left = 0;
  logic hold_go = 1'b0;

  // shadow of the block state
  logic [7:0]  master_vol;
  logic [6:0]  ch_vol [16];
  logic [7:0]  ch_bend [16];
  logic [6:0]  ch_prog [16];
  logic [4:0]  ch_voice [16];
  bit          ch_held [16];
  logic [6:0]  ch_note [16];
  logic [1:0]  busy [32];
  logic [31:0] patch_mem [4096];

  // stimulus-side bookkeeping
  logic [6:0]  gen_prog [16];
  logic [6:0]  gen_note [16];
  logic [15:0] gen_written [256];

  function automatic logic [5:0] atten(int lvl);
    return 6'(63 - ((lvl & 127) >> 1));
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic silence_state();
    for (int i = 0; i < 16; i++) begin
      ch_vol[i] = fmva_pkg::VOLUME_RESET;
      ch_bend[i] = fmva_pkg::BEND_RESET;
      ch_held[i] = 0;
      ch_voice[i] = '0;
    end
    for (int i = 0; i < 32; i++) busy[i] = '0;
  endtask

  task automatic push_write(int idx, logic [31:0] val, bit clr, bit lst);
    fmva_pkg::res_t r;
    r.reg_index = 7'(idx);
    r.reg_value = val;
    r.clear_all = clr;
    r.last = lst;
    voice_write_q.push_back(r);
  endtask

  task automatic play_note(int ch, int d0, int vel);
    int slot, base, nt, n1, n2, vol, modv, carv, pbl, code, vn1, vn2, fn;
    logic [31:0] w [5];
    logic [7:0] fixflag, fineadj, fixnote, modfcn, modlvl, fbconn, carfcn, carlvl;
    logic [31:0] rv1, rv2;
    bit pair;
    slot = (int'(ch_prog[ch]) + (ch == fmva_pkg::DRUM_CHANNEL ? 128 : 0)) % 256;
    for (int k = 0; k < 5; k++) w[k] = patch_mem[slot * 16 + k];
    fixflag = w[0][7:0];
    fineadj = w[0][23:16];
    fixnote = w[0][31:24];
    modfcn = w[1][31:24];
    modlvl = w[2][15:8];
    fbconn = w[2][23:16];
    carfcn = w[3][23:16];
    carlvl = w[4][7:0];
    base = $signed(w[4][31:16]);
    code = -1;
    if (ch_held[ch]) begin
      code = ch_voice[ch];
    end else begin
      pair = !fbconn[0] || modfcn != carfcn || fixflag[2];
      if (pair)
        for (int i = 0; i < 16 && code < 0; i++)
          if (busy[2*i] == 0 && busy[2*i+1] == 0) code = 16 | i;
      for (int i = 0; i < 16 && code < 0; i++)
        if (busy[2*i] == 0) code = i;
      if (code < 0) return;
    end
    code = code & 31;
    ch_voice[ch] = 5'(code);
    ch_held[ch] = 1;
    ch_note[ch] = 7'(d0);
    vn1 = ((code & 15) * 2) & 31;
    vn2 = (vn1 + 1) & 31;
    nt = d0 + base;
    if (nt < 0) nt = 0;
    if (fixflag[0]) nt = fixnote;
    n1 = clip(nt, 0, 127);
    n2 = clip(nt + int'(fineadj) - 128, 0, 127);
    vol = (int'(ch_vol[ch]) * vel) >> 7;
    vol = clip((vol * int'(master_vol)) >> 4, 0, 127);
    modv = 63 - (modlvl & 63);
    carv = 63 - (carlvl & 63);
    pbl = ch_bend[ch];
    if (pbl != 0) pbl = (pbl >> 3) - 16;
    nt = clip(d0 + pbl, 0, 127);
    fn = (ch == fmva_pkg::DRUM_CHANNEL) ? fmva_pkg::FN_DRUM : fmva_pkg::FN_MELODIC;
    if (modfcn == carfcn) fn = modfcn;
    if (!fbconn[0]) begin
      carv = (carv * vol) >> 6;
      case (fbconn[3:1])
        3'd0: modv = 0;
        3'd1: modv = modv >> 4;
        3'd2: modv = modv >> 3;
        3'd3: modv = modv >> 2;
        3'd4: modv = modv >> 1;
        3'd5: ;
        3'd6: modv = modv << 1;
        default: modv = modv << 2;
      endcase
      modv = (modv << 1) & 255;
    end else begin
      modv = (modv * vol) >> 6;
      carv = (carv * vol) >> 6;
      fn = modfcn;
    end
    if (modv > 127) modv = 127;
    if (carv > 127) carv = 127;
    if (code & 16) begin
      rv1 = {1'b0, carfcn[2:0], atten(carv), 2'b00, fmva_pkg::NOTE_STEP[n1]};
      rv2 = {1'b0, modfcn[2:0], atten(modv), 2'b00, fmva_pkg::NOTE_STEP[n2]};
      if (!fbconn[0]) rv1[21] = 1'b1;
      busy[vn1] = busy[vn1] | 2'd1;
      busy[vn2] = busy[vn2] | 2'd2;
      push_write(vn1 * 4, rv1, 0, 0);
      push_write(vn2 * 4, rv2, 0, 1);
    end else begin
      rv1 = {4'(fn), atten(vol), 2'b00, fmva_pkg::NOTE_STEP[nt]};
      busy[vn1] = busy[vn1] | 2'd2;
      push_write(vn1 * 4, rv1, 0, 1);
    end
  endtask

  task automatic release_note(int ch, logic [6:0] d0);
    int code, vn1;
    if (!ch_held[ch] || ch_note[ch] != d0) return;
    code = ch_voice[ch];
    ch_held[ch] = 0;
    vn1 = (code & 15) * 2;
    busy[vn1] = '0;
    if (code & 16) begin
      busy[vn1 + 1] = '0;
      push_write(vn1 * 4, '0, 0, 0);
      push_write((vn1 + 1) * 4, '0, 0, 1);
    end else begin
      push_write(vn1 * 4, '0, 0, 1);
    end
  endtask

  task automatic apply_event(fmva_pkg::msg_t m);
    case (m.kind)
      fmva_pkg::KIND_NOTE_ON:    play_note(m.channel, m.note, m.velocity);
      fmva_pkg::KIND_NOTE_OFF:   release_note(m.channel, m.note);
      fmva_pkg::KIND_PITCH_BEND: ch_bend[m.channel] = m.bend[13:6];
      fmva_pkg::KIND_CONTROLLER: begin
        if (m.ctrl_number == fmva_pkg::CTRL_VOLUME) ch_vol[m.channel] = m.ctrl_value;
      end
      fmva_pkg::KIND_PROGRAM:    ch_prog[m.channel] = m.program_req;
      fmva_pkg::KIND_LOAD_PATCH: begin
        patch_mem[{m.patch_index, m.patch_word_index}] = m.patch_word;
      end
      fmva_pkg::KIND_SILENCE: begin
        silence_state();
        push_write(0, '0, 1, 1);
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst && (!msg_valid || !msg_stall)) begin
      if (msg_valid) begin
        apply_event(msg);
        void'(event_q.pop_front());
      end
      if (event_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        msg <= event_q[0];
        msg_valid <= 1'b1;
      end else begin
        msg_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // monitor
  always @(posedge clk) begin
    fmva_pkg::res_t e;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        writes_seen++;
        if (voice_write_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer idx=%0d val=%h clr=%b last=%b", $time,
                   res.reg_index, res.reg_value, res.clear_all, res.last);
        end else begin
          e = voice_write_q.pop_front();
          if (res !== e) begin
            errors++;
            $display("%0t: mismatch expected idx=%0d val=%h clr=%b last=%b", $time,
                     e.reg_index, e.reg_value, e.clear_all, e.last);
            $display("%0t:          actual   idx=%0d val=%h clr=%b last=%b", $time,
                     res.reg_index, res.reg_value, res.clear_all, res.last);
          end
        end
      end
      res_stall <= (hold_left > 1) || ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout: %0d writes still outstanding", voice_write_q.size());
      $display("midi_fm_voice_allocator_unit regression: fail");
      $finish;
    end
  end

  function automatic fmva_pkg::msg_t noise();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return fmva_pkg::msg_t'(r[$bits(fmva_pkg::msg_t)-1:0]);
  endfunction

  task automatic send(fmva_pkg::msg_t m);
    if (m.kind == fmva_pkg::KIND_LOAD_PATCH)
      gen_written[m.patch_index][m.patch_word_index] = 1'b1;
    if (m.kind == fmva_pkg::KIND_PROGRAM) gen_prog[m.channel] = m.program_req;
    if (m.kind == fmva_pkg::KIND_NOTE_ON) gen_note[m.channel] = m.note;
    event_q.push_back(m);
    events_sent++;
  endtask

  task automatic load_word(int slot, int k, logic [31:0] w);
    fmva_pkg::msg_t m;
    m = noise();
    m.kind = fmva_pkg::KIND_LOAD_PATCH;
    m.patch_index = 8'(slot);
    m.patch_word_index = 4'(k);
    m.patch_word = w;
    send(m);
  endtask

  task automatic load_voice_words(int slot, bit all);
    logic [31:0] w [5];
    for (int k = 0; k < 5; k++) w[k] = $urandom;
    if ($urandom_range(1)) w[0][2] = 1'b0;
    if ($urandom_range(3) == 0) w[0][0] = 1'b0;
    if ($urandom_range(1)) w[3][23:16] = w[1][31:24];
    if ($urandom_range(4) != 0) w[4][31:16] = 16'($signed($urandom_range(80)) - 40);
    for (int k = 0; k < 5; k++)
      if (all || !gen_written[slot][k]) load_word(slot, k, w[k]);
  endtask

  task automatic note_on(int ch, int nt, int vel);
    fmva_pkg::msg_t m;
    load_voice_words((int'(gen_prog[ch]) + (ch == fmva_pkg::DRUM_CHANNEL ? 128 : 0)) % 256,
                     0);
    m = noise();
    m.kind = fmva_pkg::KIND_NOTE_ON;
    m.channel = 4'(ch);
    m.note = 7'(nt);
    m.velocity = 7'(vel);
    send(m);
  endtask

  task automatic simple(logic [2:0] k, int ch);
    fmva_pkg::msg_t m;
    m = noise();
    m.kind = k;
    m.channel = 4'(ch);
    if (k == fmva_pkg::KIND_NOTE_OFF && $urandom_range(4) != 0) m.note = gen_note[ch];
    if (k == fmva_pkg::KIND_CONTROLLER && $urandom_range(1))
      m.ctrl_number = fmva_pkg::CTRL_VOLUME;
    send(m);
  endtask

  task automatic random_event();
    int p, ch;
    p = $urandom_range(99);
    ch = $urandom_range(15);
    if (p < 32) note_on(ch, $urandom_range(127), $urandom_range(127));
    else if (p < 58) simple(fmva_pkg::KIND_NOTE_OFF, ch);
    else if (p < 66) simple(fmva_pkg::KIND_PITCH_BEND, ch);
    else if (p < 75) simple(fmva_pkg::KIND_CONTROLLER, ch);
    else if (p < 83) simple(fmva_pkg::KIND_PROGRAM, ch);
    else if (p < 88) load_voice_words($urandom_range(255), 1);
    else if (p < 94) simple(fmva_pkg::KIND_LOAD_PATCH, ch);
    else if (p < 97) simple(fmva_pkg::KIND_SILENCE, ch);
    else simple(KIND_UNUSED, ch);
  endtask

  task automatic settle();
    do @(posedge clk); while (event_q.size() != 0 || msg_valid || voice_write_q.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_master(logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    master_vol = v;
  endtask

  task automatic run_phase(int s_idle, int r_idle, logic [7:0] mv, int n);
    send_idle = s_idle;
    recv_idle = r_idle;
    set_master(mv);
    repeat (n) random_event();
    settle();
  endtask

  initial begin
    fmva_pkg::msg_t m;
    master_vol = fmva_pkg::MASTER_RESET;
    silence_state();
    for (int i = 0; i < 16; i++) begin
      ch_prog[i] = '0;
      ch_note[i] = '0;
      gen_prog[i] = '0;
      gen_note[i] = '0;
    end
    for (int i = 0; i < 256; i++) gen_written[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every kind, reset master volume
    note_on(0, 0, 127);
    simple(fmva_pkg::KIND_NOTE_OFF, 0);
    note_on(fmva_pkg::DRUM_CHANNEL, 127, 0);
    m = noise(); m.kind = fmva_pkg::KIND_PITCH_BEND; m.channel = 4'd1; m.bend = 14'h3FFF;
    send(m);
    m = noise(); m.kind = fmva_pkg::KIND_PITCH_BEND; m.channel = 4'd2; m.bend = '0;
    send(m);
    note_on(1, 127, 127);
    note_on(2, 0, 1);
    m = noise(); m.kind = fmva_pkg::KIND_CONTROLLER; m.channel = 4'd3;
    m.ctrl_number = fmva_pkg::CTRL_VOLUME; m.ctrl_value = '0; send(m);
    note_on(3, 64, 127);
    m = noise(); m.kind = fmva_pkg::KIND_PROGRAM; m.channel = 4'd15; m.program_req = 7'h7F;
    send(m);
    note_on(15, 60, 100);
    m = noise(); m.kind = fmva_pkg::KIND_NOTE_OFF; m.channel = 4'd15; m.note = 7'd61;
    send(m);
    simple(KIND_UNUSED, 4);
    simple(fmva_pkg::KIND_SILENCE, 5);
    note_on(4, 30, 90);
    settle();

    run_phase(0, 0, 8'd0, 170);
    run_phase(58, 0, 8'd255, 200);
    run_phase(0, 58, 8'd16, 200);

    // fill the block while the receiver holds off, then pause for a full drain
    send_idle = 0;
    recv_idle = 0;
    @(posedge clk) hold_go <= 1'b1;
    @(posedge clk) hold_go <= 1'b0;
    repeat (40) note_on($urandom_range(15), $urandom_range(127), $urandom_range(127));
    do @(posedge clk); while (event_q.size() != 0 || voice_write_q.size() != 0);
    repeat (100) random_event();
    settle();

    run_phase(27, 27, 8'($urandom), 200);
    run_phase(0, 0, fmva_pkg::MASTER_RESET, 170);
    run_phase(27, 27, 8'd255, 130);

    $display("%0d events sent, %0d voice writes checked", events_sent, writes_seen);
    $display("master volume 0..255, idle and stall mixes, long receiver hold-off");
    if (errors == 0) begin
      $display("midi_fm_voice_allocator_unit regression: pass");
    end else begin
      $display("midi_fm_voice_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- midi_fm_voice_allocator_unit.f -----
design/fmva_pkg.sv
design/fmva_datapath.sv
design/fmva_control.sv
design/midi_fm_voice_allocator_unit.sv
tb/midi_fm_voice_allocator_unit_tb.sv
